// ===== sv/premultiplied_hsl_shift_macros.svh =====
// Assertion macros for the premultiplied HSL shift block.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef PREMULTIPLIED_HSL_SHIFT_MACROS_SVH
`define PREMULTIPLIED_HSL_SHIFT_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define PHS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequence must hold in the cycle after the condition.
`define PHS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/phs_pkg.sv =====
// Shared types, widths, codes and helper functions of the premultiplied HSL shift.
// Used by phs_ctrl, phs_chan and premultiplied_hsl_shift; depends on nothing.
`default_nettype none

package phs_pkg;

	// Pipeline depth and the position of each stage in the control vectors.
	localparam int NUM_STAGES = 6;
	localparam int ST_S1 = 0;
	localparam int ST_S2 = 1;
	localparam int ST_S3 = 2;
	localparam int ST_S4 = 3;
	localparam int ST_S5 = 4;
	localparam int ST_S6 = 5;

	// Field and datapath widths.
	localparam int C_W       = 8;   // one colour or alpha channel
	localparam int CFG_W     = 18;  // a shift register
	localparam int CFG_IDX_W = 2;   // configuration register index
	localparam int M_W       = 9;   // max + min of the channels
	localparam int X_W       = 10;  // signed first multiplier operand
	localparam int COEF_W    = 17;  // unsigned first multiplier coefficient
	localparam int SN_W      = 10;  // coarse saturation factor
	localparam int LN_W      = 12;  // coarse lightness factor
	localparam int MS_W      = 19;  // max + min times coarse saturation
	localparam int P_W       = 28;  // first product
	localparam int R_W       = 12;  // result of the single-shift modes
	localparam int T_W       = 21;  // coarse intermediate and its difference
	localparam int TT_W      = 31;  // coarse intermediate scaled by 1024
	localparam int Q_W       = 34;  // second product and final numerator
	localparam int V_W       = 14;  // final value before saturation

	// Bit positions used by the fixed-point scaling.
	localparam int FRAC_MSB  = 14;  // top bit of a shift below one half
	localparam int COARSE_SH = 5;   // Q16 to Q11 (divide by 32)
	localparam int SH_FINE   = 15;  // c * 2x / 65536 == c * x >> 15
	localparam int SH_SAT    = 16;  // saturation-only denominator
	localparam int SH_T      = 9;   // max + min times 512
	localparam int SH_A      = 10;  // scaling by 1024
	localparam int SH_COARSE = 20;  // 1024 * 1024 denominator

	// Q16 thresholds of the shift registers.
	localparam logic signed [CFG_W-1:0] DEC_MAX  = 18'sd32735;
	localparam logic signed [CFG_W-1:0] INC_MIN  = 18'sd32801;
	localparam logic signed [CFG_W-1:0] Q16_HALF = 18'sd32768;
	localparam logic signed [CFG_W-1:0] Q16_ONE  = 18'sd65536;
	localparam logic signed [CFG_W-1:0] CFG_RESET = -18'sd1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_HUE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIGHT = 2'd2;

	// Direction requested by one shift register.
	typedef logic [1:0] shift_t;
	localparam shift_t SHIFT_NONE = 2'd0;
	localparam shift_t SHIFT_DEC  = 2'd1;
	localparam shift_t SHIFT_INC  = 2'd2;

	// Processing mode of one pixel.
	typedef logic [2:0] mode_t;
	localparam mode_t MODE_PASS  = 3'd0;  // copy the channels
	localparam mode_t MODE_LDEC  = 3'd1;  // darken only
	localparam mode_t MODE_LINC  = 3'd2;  // lighten only
	localparam mode_t MODE_SDEC  = 3'd3;  // desaturate only
	localparam mode_t MODE_SLDEC = 3'd4;  // desaturate and darken
	localparam mode_t MODE_SLINC = 3'd5;  // desaturate and lighten

	// Stage enables and valid bits handed from the pipeline control to the datapath.
	typedef struct packed {
		logic [NUM_STAGES-1:0] en;
		logic [NUM_STAGES-1:0] vld;
	} pipe_ctl_t;

	// Classify a shift register value against the band around one half.
	function automatic shift_t classify(input logic signed [CFG_W-1:0] v);
		shift_t res;
		if (v[CFG_W-1]) begin
			res = SHIFT_NONE;
		end else if (v <= DEC_MAX) begin
			res = SHIFT_DEC;
		end else if (v >= INC_MIN) begin
			res = SHIFT_INC;
		end else begin
			res = SHIFT_NONE;
		end
		return res;
	endfunction

	// Clamp a signed value to an 8-bit channel.
	function automatic logic [C_W-1:0] sat8(input logic signed [V_W-1:0] v);
		logic [C_W-1:0] res;
		if (v[V_W-1]) begin
			res = '0;
		end else if (|v[V_W-2:C_W]) begin
			res = '1;
		end else begin
			res = v[C_W-1:0];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== sv/premultiplied_hsl_shift.sv =====
// Premultiplied HSL shift: one ARGB pixel a transfer on a six-stage pipeline.
// Depends on phs_pkg, phs_ctrl and phs_chan.
//
// Use of the block:
// - Pixels arrive on the s_axis channel and results leave on the m_axis channel.
//   s_axis_tdata holds alpha, red, green, blue from bit 0 up; m_axis_tdata holds
//   the same four channels after the shift, and m_axis_tuser flags a pixel that
//   was copied because a hue shift or a saturation increase is requested.
// - The hue, saturation and lightness shifts are written over cfg_we, cfg_index
//   and cfg_data while no pixel is in flight; an index beyond the three is ignored.
// - A pixel transferred on s_axis moves through the six register stages and is
//   offered on m_axis from the last. One pixel can be transferred every cycle
//   while the output is not stalled, since each stage holds one pixel and loads in
//   any cycle in which its content moves on; the multipliers are spread over stages.
// - While m_axis_tready is low the output holds its result, and upstream stages
//   keep loading until every stage is full; s_axis_tready falls only then.
// - Reset empties the pipeline and sets all three shifts to -1, no shift.
`default_nettype none

module premultiplied_hsl_shift (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// Configuration write port.
	input  wire logic                             cfg_we,
	input  wire logic [phs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [phs_pkg::CFG_W-1:0]        cfg_data,
	// Input pixel stream.
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  wire logic [4*phs_pkg::C_W-1:0]        s_axis_tdata,  // alpha, red, green, blue
	// Output pixel stream.
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	output logic [4*phs_pkg::C_W-1:0]             m_axis_tdata,  // alpha, red, green, blue
	output logic [0:0]                            m_axis_tuser   // unsupported
);
	import phs_pkg::*;

	localparam int NCH = 3;

	pipe_ctl_t ctl;

	// Configuration registers.
	logic signed [CFG_W-1:0] hue_q;
	logic signed [CFG_W-1:0] sat_q;
	logic signed [CFG_W-1:0] light_q;

	// Mode decode from the configuration.
	shift_t                  sop;
	shift_t                  lop;
	logic                    hop;
	logic                    unsup_d;
	logic signed [CFG_W-1:0] l_off;
	mode_t                   mode_d;
	logic [COEF_W-1:0]       coef_d;
	logic [LN_W-1:0]         ln_d;

	// Stage 1 registers.
	logic [C_W-1:0]    a_s1;
	logic [C_W-1:0]    c_s1 [NCH];
	mode_t             mode_s1;
	logic [COEF_W-1:0] coef_s1;
	logic [LN_W-1:0]   ln_s1;
	logic              unsup_s1;

	// Stage 2 logic and registers.
	logic [C_W-1:0]        vmax;
	logic [C_W-1:0]        vmin;
	logic [M_W-1:0]        msum;
	logic signed [X_W-1:0] x_d [NCH];
	logic [C_W-1:0]        a_s2;
	logic [C_W-1:0]        c_s2 [NCH];
	logic signed [X_W-1:0] x_s2 [NCH];
	logic [M_W-1:0]        m_s2;
	mode_t                 mode_s2;
	logic [COEF_W-1:0]     coef_s2;
	logic [LN_W-1:0]       ln_s2;
	logic                  unsup_s2;

	// Shared product and the alpha and flag delay line.
	logic [MS_W-1:0] ms_s3;
	logic [C_W-1:0]  a_s3, a_s4, a_s5, a_s6;
	logic            unsup_s3, unsup_s4, unsup_s5, unsup_s6;
	logic [C_W-1:0]  chan_s6 [NCH];

	// Configuration writes; an unknown index changes nothing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_q   <= CFG_RESET;
			sat_q   <= CFG_RESET;
			light_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HUE:   hue_q   <= cfg_data;
				REG_SAT:   sat_q   <= cfg_data;
				REG_LIGHT: light_q <= cfg_data;
				default:   hue_q   <= hue_q;
			endcase
		end
	end

	// Pipeline control.
	phs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.out_ready (m_axis_tready),
		.ctl       (ctl)
	);

	assign s_axis_tready = ctl.en[ST_S1];
	assign m_axis_tvalid = ctl.vld[ST_S6];

	// Pick the mode and its coefficients from the shift registers.
	always_comb begin
		sop     = classify(sat_q);
		lop     = classify(light_q);
		hop     = !hue_q[CFG_W-1] && (hue_q <= Q16_ONE);
		unsup_d = hop || (sop == SHIFT_INC);
		l_off   = light_q - Q16_HALF;
		mode_d  = MODE_PASS;
		if (!unsup_d) begin
			case (sop)
				SHIFT_NONE: begin
					if (lop == SHIFT_DEC) begin
						mode_d = MODE_LDEC;
					end else if (lop == SHIFT_INC) begin
						mode_d = MODE_LINC;
					end
				end
				SHIFT_DEC: begin
					if (lop == SHIFT_DEC) begin
						mode_d = MODE_SLDEC;
					end else if (lop == SHIFT_INC) begin
						mode_d = MODE_SLINC;
					end else begin
						mode_d = MODE_SDEC;
					end
				end
				default: begin
					mode_d = MODE_PASS;
				end
			endcase
		end
		coef_d = '0;
		ln_d   = '0;
		case (mode_d)
			MODE_LDEC: coef_d = COEF_W'(light_q[FRAC_MSB:0]);
			MODE_LINC: coef_d = l_off[COEF_W-1:0];
			MODE_SDEC: coef_d = COEF_W'(sat_q[FRAC_MSB:0]);
			MODE_SLDEC: begin
				coef_d = COEF_W'(sat_q[FRAC_MSB:COARSE_SH]);
				ln_d   = LN_W'(light_q[FRAC_MSB:COARSE_SH]);
			end
			MODE_SLINC: begin
				coef_d = COEF_W'(sat_q[FRAC_MSB:COARSE_SH]);
				ln_d   = l_off[COARSE_SH+LN_W-1:COARSE_SH];
			end
			default: begin
				coef_d = '0;
			end
		endcase
	end

	// Stage 1: capture the pixel with its mode.
	always_ff @(posedge clk) begin
		if (ctl.en[ST_S1]) begin
			a_s1 <= s_axis_tdata[C_W-1:0];
			for (int i = 0; i < NCH; i++) begin
				c_s1[i] <= s_axis_tdata[(i+1)*C_W +: C_W];
			end
			mode_s1  <= mode_d;
			coef_s1  <= coef_d;
			ln_s1    <= ln_d;
			unsup_s1 <= unsup_d;
		end
	end

	// Stage 2: max + min of the channels and the first multiplier operand.
	always_comb begin
		vmax = c_s1[0];
		vmin = c_s1[0];
		for (int i = 1; i < NCH; i++) begin
			if (c_s1[i] > vmax) begin
				vmax = c_s1[i];
			end
			if (c_s1[i] < vmin) begin
				vmin = c_s1[i];
			end
		end
		msum = {1'b0, vmax} + {1'b0, vmin};
		for (int i = 0; i < NCH; i++) begin
			case (mode_s1)
				MODE_LINC: x_d[i] = X_W'({1'b0, a_s1}) - X_W'({1'b0, c_s1[i]});
				MODE_SDEC: x_d[i] = X_W'({c_s1[i], 1'b0}) - X_W'(msum);
				default:   x_d[i] = X_W'(c_s1[i]);
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en[ST_S2]) begin
			a_s2 <= a_s1;
			for (int i = 0; i < NCH; i++) begin
				c_s2[i] <= c_s1[i];
				x_s2[i] <= x_d[i];
			end
			m_s2     <= msum;
			mode_s2  <= mode_s1;
			coef_s2  <= coef_s1;
			ln_s2    <= ln_s1;
			unsup_s2 <= unsup_s1;
		end
	end

	// Stage 3: max + min times the coarse saturation, shared by the channels.
	always_ff @(posedge clk) begin
		if (ctl.en[ST_S3]) begin
			ms_s3    <= MS_W'(m_s2) * MS_W'(coef_s2[SN_W-1:0]);
			a_s3     <= a_s2;
			unsup_s3 <= unsup_s2;
		end
	end

	// Alpha and the flag follow the colour channels to the output.
	always_ff @(posedge clk) begin
		if (ctl.en[ST_S4]) begin
			a_s4     <= a_s3;
			unsup_s4 <= unsup_s3;
		end
		if (ctl.en[ST_S5]) begin
			a_s5     <= a_s4;
			unsup_s5 <= unsup_s4;
		end
		if (ctl.en[ST_S6]) begin
			a_s6     <= a_s5;
			unsup_s6 <= unsup_s5;
		end
	end

	// One datapath per colour channel.
	for (genvar gi = 0; gi < NCH; gi++) begin : g_chan
		phs_chan u_chan (
			.clk     (clk),
			.ctl     (ctl),
			.mode_s2 (mode_s2),
			.x_s2    (x_s2[gi]),
			.c_s2    (c_s2[gi]),
			.a_s2    (a_s2),
			.m_s2    (m_s2),
			.coef_s2 (coef_s2),
			.ln_s2   (ln_s2),
			.ms_s3   (ms_s3),
			.out_s6  (chan_s6[gi])
		);
	end

	assign m_axis_tdata = {chan_s6[2], chan_s6[1], chan_s6[0], a_s6};
	assign m_axis_tuser = unsup_s6;

endmodule

`default_nettype wire

// ===== sv/phs_ctrl.sv =====
// Valid and stall control of the six-stage pixel pipeline.
// Depends on phs_pkg and on the assertion macros in premultiplied_hsl_shift_macros.svh.
`default_nettype none
`include "premultiplied_hsl_shift_macros.svh"

module phs_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              out_ready,
	output phs_pkg::pipe_ctl_t     ctl
);
	import phs_pkg::*;

	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] en;
	logic                  in_acc;
	logic                  out_acc;

	// A stage may load when it is empty or when its content moves on, so
	// bubbles are squeezed out while the output is stalled.
	always_comb begin
		en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || out_ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign ctl.en  = en;
	assign ctl.vld = vld_q;

	assign in_acc  = in_valid && en[ST_S1];
	assign out_acc = vld_q[ST_S6] && out_ready;

	// Checks on the pipeline bookkeeping.
	`PHS_ASSERT_SAME(a_ready_when_tail_empty, !vld_q[ST_S6], en[ST_S1],
		"input not ready although the output stage is empty")
	`PHS_ASSERT_NEXT(a_accept_lands_in_s1, in_acc, vld_q[ST_S1],
		"accepted transfer did not reach the first stage")
	`PHS_ASSERT_NEXT(a_count_up, in_acc && !out_acc,
		$countones(vld_q) == $past($countones(vld_q)) + 1,
		"item count did not grow on an input-only transfer")
	`PHS_ASSERT_NEXT(a_count_down, !in_acc && out_acc,
		$countones(vld_q) == $past($countones(vld_q)) - 1,
		"item count did not shrink on an output-only transfer")

endmodule

`default_nettype wire

// ===== sv/phs_chan.sv =====
// Datapath of one colour channel, stages three to six of the pixel pipeline.
// Depends on phs_pkg; its operands come from the first two stages in the top level.
`default_nettype none

module phs_chan (
	input  wire logic                           clk,
	input  wire phs_pkg::pipe_ctl_t             ctl,
	input  wire phs_pkg::mode_t                 mode_s2,
	input  wire logic signed [phs_pkg::X_W-1:0] x_s2,
	input  wire logic [phs_pkg::C_W-1:0]        c_s2,
	input  wire logic [phs_pkg::C_W-1:0]        a_s2,
	input  wire logic [phs_pkg::M_W-1:0]        m_s2,
	input  wire logic [phs_pkg::COEF_W-1:0]     coef_s2,
	input  wire logic [phs_pkg::LN_W-1:0]       ln_s2,
	input  wire logic [phs_pkg::MS_W-1:0]       ms_s3,
	output logic [phs_pkg::C_W-1:0]             out_s6
);
	import phs_pkg::*;

	// Stage 3 registers.
	mode_t                 mode_s3;
	logic signed [P_W-1:0] p_s3;
	logic [C_W-1:0]        c_s3;
	logic [C_W-1:0]        a_s3;
	logic [M_W-1:0]        m_s3;
	logic [LN_W-1:0]       ln_s3;

	// Stage 4 registers.
	mode_t                 mode_s4;
	logic signed [R_W-1:0] r_s4;
	logic signed [T_W-1:0] w_s4;
	logic [TT_W-1:0]       tt_s4;
	logic [LN_W-1:0]       ln_s4;

	// Stage 5 registers.
	mode_t                 mode_s5;
	logic signed [R_W-1:0] r_s5;
	logic signed [Q_W-1:0] q_s5;
	logic [TT_W-1:0]       tt_s5;

	// Stage 4 logic.
	logic signed [P_W-1:0] p_rnd;
	logic signed [P_W-1:0] sd_num;
	logic signed [T_W-1:0] t_val;
	logic signed [R_W-1:0] r_d;
	logic signed [T_W-1:0] w_d;
	logic [TT_W-1:0]       tt_d;

	// Stage 6 logic.
	logic signed [Q_W-1:0] num;
	logic signed [Q_W-1:0] num_rnd;
	logic signed [V_W-1:0] v_d;

	// First product: the channel, its distance to alpha or twice its distance to the
	// midpoint of max and min, times the coefficient chosen for the mode.
	always_ff @(posedge clk) begin
		if (ctl.en[ST_S3]) begin
			mode_s3 <= mode_s2;
			p_s3    <= P_W'(x_s2) * P_W'($signed({1'b0, coef_s2}));
			c_s3    <= c_s2;
			a_s3    <= a_s2;
			m_s3    <= m_s2;
			ln_s3   <= ln_s2;
		end
	end

	// Finish the single-shift modes and form the coarse intermediate otherwise.
	always_comb begin
		p_rnd  = p_s3 + (p_s3[P_W-1] ? P_W'((1 << SH_FINE) - 1) : P_W'(0));
		sd_num = P_W'({m_s3, {SH_FINE{1'b0}}}) + p_s3;
		t_val  = T_W'({m_s3, {SH_T{1'b0}}}) + T_W'(p_s3) - T_W'(ms_s3 >> 1);
		r_d    = R_W'(c_s3);
		w_d    = t_val;
		tt_d   = '0;
		case (mode_s3)
			MODE_LDEC: begin
				r_d = p_s3[SH_FINE+R_W-1:SH_FINE];
			end
			MODE_LINC: begin
				r_d = R_W'(c_s3) + p_rnd[SH_FINE+R_W-1:SH_FINE];
			end
			MODE_SDEC: begin
				r_d = sd_num[SH_SAT+R_W-1:SH_SAT];
			end
			MODE_SLINC: begin
				w_d  = T_W'({a_s3, {SH_A{1'b0}}}) - t_val;
				tt_d = {t_val, {SH_A{1'b0}}};
			end
			default: begin
				r_d = R_W'(c_s3);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.en[ST_S4]) begin
			mode_s4 <= mode_s3;
			r_s4    <= r_d;
			w_s4    <= w_d;
			tt_s4   <= tt_d;
			ln_s4   <= ln_s3;
		end
	end

	// Second product, used only when both shifts are active.
	always_ff @(posedge clk) begin
		if (ctl.en[ST_S5]) begin
			mode_s5 <= mode_s4;
			r_s5    <= r_s4;
			q_s5    <= Q_W'(w_s4) * Q_W'($signed({1'b0, ln_s4}));
			tt_s5   <= tt_s4;
		end
	end

	// In the two-shift modes divide by 1024 * 1024 toward zero; then clamp to a channel.
	always_comb begin
		num     = q_s5 + Q_W'(tt_s5);
		num_rnd = num + (num[Q_W-1] ? Q_W'((1 << SH_COARSE) - 1) : Q_W'(0));
		case (mode_s5)
			MODE_SLDEC, MODE_SLINC: begin
				v_d = num_rnd[SH_COARSE+V_W-1:SH_COARSE];
			end
			default: begin
				v_d = {{(V_W-R_W){r_s5[R_W-1]}}, r_s5};
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.en[ST_S6]) begin
			out_s6 <= sat8(v_d);
		end
	end

endmodule

`default_nettype wire

// ===== bench/tb_premultiplied_hsl_shift.sv =====
// Self-checking testbench for the premultiplied HSL shift block.
// Depends on phs_pkg and premultiplied_hsl_shift; pixels are checked against a local predictor.
`timescale 1ns / 100ps

module tb_premultiplied_hsl_shift;
	import phs_pkg::*;

	// Index that selects no register; writes to it must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam longint FINE_DEN   = 65536;
	localparam longint COARSE_DEN = 1024;
	localparam int HOLD_CYCLES    = 200;
	localparam int QUIET_LIMIT    = 2000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int RANDOM_PIXELS  = 1200;

	// One pixel as it travels in tdata: alpha in the lowest byte.
	typedef struct packed {
		logic [C_W-1:0] blue;
		logic [C_W-1:0] green;
		logic [C_W-1:0] red;
		logic [C_W-1:0] alpha;
	} pixel_t;

	typedef struct {
		logic [C_W-1:0] alpha;
		logic [C_W-1:0] red;
		logic [C_W-1:0] green;
		logic [C_W-1:0] blue;
		logic           unsupported;
	} shifted_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_W-1:0]        cfg_data;
	logic                    s_axis_tvalid;
	logic                    s_axis_tready;
	logic [4*C_W-1:0]        s_axis_tdata;   // alpha, red, green, blue
	logic                    m_axis_tvalid;
	logic                    m_axis_tready;
	logic [4*C_W-1:0]        m_axis_tdata;   // alpha, red, green, blue
	logic [0:0]              m_axis_tuser;   // unsupported

	// Shadow copy of the shift registers.
	logic signed [CFG_W-1:0] hue_r;
	logic signed [CFG_W-1:0] sat_r;
	logic signed [CFG_W-1:0] light_r;

	pixel_t   pixels_to_send[$];
	shifted_t pending_shifted[$];
	int       pixels_queued;
	int       pixels_accepted;
	int       pixels_checked;
	int       err_count;
	int       quiet_cycles;
	int       hold_left;
	bit       hold_req;
	bit       hold_done;
	pixel_t   got_px;
	shifted_t want;

	premultiplied_hsl_shift dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #4 clk = ~clk;

	// Direction requested by a shift register, with the no-shift band around one half.
	function automatic shift_t shift_dir(input logic signed [CFG_W-1:0] v);
		if (v >= 0 && v <= DEC_MAX)
			return SHIFT_DEC;
		if (v >= INC_MIN)
			return SHIFT_INC;
		return SHIFT_NONE;
	endfunction

	function automatic logic [C_W-1:0] clamp_channel(input longint v);
		if (v < 0)
			return '0;
		if (v > 255)
			return '1;
		return v[C_W-1:0];
	endfunction

	// Expected result of one pixel under the current shadow registers.
	function automatic shifted_t shift_pixel(input pixel_t px);
		shifted_t res;
		shift_t   sop;
		shift_t   lop;
		logic     unsup;
		longint   a, s, l, vmax, vmin, m, sn, ln, t, v;
		longint   ch[3];
		logic [C_W-1:0] outc[3];
		sop = shift_dir(sat_r);
		lop = shift_dir(light_r);
		unsup = (hue_r >= 0 && hue_r <= Q16_ONE) || sop == SHIFT_INC;
		a = longint'(px.alpha);
		s = longint'(sat_r);
		l = longint'(light_r);
		ch[0] = longint'(px.red);
		ch[1] = longint'(px.green);
		ch[2] = longint'(px.blue);
		vmax = ch[0];
		vmin = ch[0];
		for (int i = 1; i < 3; i++) begin
			if (ch[i] > vmax)
				vmax = ch[i];
			if (ch[i] < vmin)
				vmin = ch[i];
		end
		m = vmax + vmin;
		for (int i = 0; i < 3; i++) begin
			v = ch[i];
			if (unsup) begin
				v = ch[i];
			end else if (sop == SHIFT_NONE) begin
				if (lop == SHIFT_DEC)
					v = ch[i] * (2 * l) / FINE_DEN;
				else if (lop == SHIFT_INC)
					v = ch[i] + (a - ch[i]) * (2 * (l - longint'(Q16_HALF))) / FINE_DEN;
			end else if (lop == SHIFT_NONE) begin
				v = (m * (FINE_DEN / 2) + ch[i] * 2 * s - m * s) / FINE_DEN;
			end else begin
				// Both shifts at once use the coarse 1024 denominator.
				sn = s / 32;
				t = m * (COARSE_DEN / 2) + ch[i] * sn - (m * sn) / 2;
				if (lop == SHIFT_DEC) begin
					ln = l / 32;
					v = t * ln / (COARSE_DEN * COARSE_DEN);
				end else begin
					ln = (l - longint'(Q16_HALF)) / 32;
					v = (t * COARSE_DEN + (a * COARSE_DEN - t) * ln) / (COARSE_DEN * COARSE_DEN);
				end
			end
			outc[i] = clamp_channel(v);
		end
		res.alpha = px.alpha;
		res.red = outc[0];
		res.green = outc[1];
		res.blue = outc[2];
		res.unsupported = unsup;
		return res;
	endfunction

	// Input driver: offers queued pixels, idling at random outside the busy stretch.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				pending_shifted.push_back(shift_pixel(s_axis_tdata));
				pixels_accepted++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pixels_to_send.size() > 0 &&
						((pixels_accepted >= 600 && pixels_accepted < 800) ||
						$urandom_range(99) >= 23)) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= pixels_to_send.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: checks each transfer and drives the receiver's ready.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				pixels_checked++;
				got_px = m_axis_tdata;
				if (pending_shifted.size() == 0) begin
					$error("unexpected pixel %h flag %b", m_axis_tdata, m_axis_tuser);
					err_count++;
				end else begin
					want = pending_shifted.pop_front();
					if (got_px.alpha !== want.alpha) begin
						$error("alpha_out expected %0d got %0d", want.alpha, got_px.alpha);
						err_count++;
					end
					if (got_px.red !== want.red) begin
						$error("red_out expected %0d got %0d", want.red, got_px.red);
						err_count++;
					end
					if (got_px.green !== want.green) begin
						$error("green_out expected %0d got %0d", want.green, got_px.green);
						err_count++;
					end
					if (got_px.blue !== want.blue) begin
						$error("blue_out expected %0d got %0d", want.blue, got_px.blue);
						err_count++;
					end
					if (m_axis_tuser[0] !== want.unsupported) begin
						$error("unsupported expected %0d got %0d", want.unsupported,
							m_axis_tuser[0]);
						err_count++;
					end
				end
			end
			// A single long hold-off lets the pipeline fill and back-pressure the input.
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= (pixels_checked >= 600 && pixels_checked < 800) ||
					$urandom_range(99) >= 23;
			end
		end
	end

	// Watchdog on cycles without any transfer or register write.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[premultiplied_hsl_shift] ERROR");
				$finish;
			end
		end
	end

	task automatic send_pixel(input pixel_t px);
		pixels_to_send.push_back(px);
		pixels_queued++;
	endtask

	task automatic wait_drained();
		while (pixels_checked != pixels_queued)
			@(posedge clk);
	endtask

	// Called just after a rising edge; returns after the edge that performs the write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic signed [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_HUE:   hue_r = val;
			REG_SAT:   sat_r = val;
			REG_LIGHT: light_r = val;
			default: ;
		endcase
	endtask

	task automatic set_shifts(input logic signed [CFG_W-1:0] h, s, l, input bit spare);
		wait_drained();
		@(posedge clk);
		if (spare)
			write_reg(REG_SPARE, CFG_W'($urandom));
		write_reg(REG_HUE, h);
		write_reg(REG_SAT, s);
		write_reg(REG_LIGHT, l);
		cfg_we <= 1'b0;
	endtask

	// Full-scale, empty, and over-alpha pixels for each directed setting.
	task automatic send_corner_pixels();
		send_pixel('{blue: 8'd255, green: 8'd255, red: 8'd255, alpha: 8'd255});
		send_pixel('{blue: 8'd0, green: 8'd0, red: 8'd0, alpha: 8'd0});
		send_pixel('{blue: 8'd100, green: 8'd0, red: 8'd255, alpha: 8'd200});
	endtask

	// Shift register value spread over every band, out-of-range ones included.
	function automatic logic signed [CFG_W-1:0] pick_shift();
		case ($urandom_range(9))
			0: return CFG_RESET;
			1: return '0;
			2: return DEC_MAX;
			3: return CFG_W'($urandom_range(32800, 32736));
			4: return INC_MIN;
			5: return Q16_ONE;
			6: return CFG_W'($urandom_range(131071, 65537));
			7: return -CFG_W'($urandom_range(131072, 2));
			default: return CFG_W'($urandom_range(65536, 0));
		endcase
	endfunction

	// Mostly well-formed premultiplied pixels; some with channels above alpha.
	function automatic pixel_t make_pixel();
		pixel_t px;
		px.alpha = C_W'($urandom_range(255));
		if ($urandom_range(99) < 85) begin
			px.red = C_W'($urandom_range(px.alpha));
			px.green = C_W'($urandom_range(px.alpha));
			px.blue = C_W'($urandom_range(px.alpha));
		end else begin
			px.red = C_W'($urandom_range(255));
			px.green = C_W'($urandom_range(255));
			px.blue = C_W'($urandom_range(255));
		end
		return px;
	endfunction

	initial begin
		int phase_len;
		int phase_no;
		logic signed [CFG_W-1:0] h;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		hue_r = CFG_RESET;
		sat_r = CFG_RESET;
		light_r = CFG_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: reset values first, then each mode at its extremes.
		send_corner_pixels();
		set_shifts(CFG_RESET, CFG_RESET, 18'sd0, 1'b0);
		send_corner_pixels();
		set_shifts(CFG_RESET, CFG_RESET, Q16_ONE, 1'b0);
		send_corner_pixels();
		set_shifts(CFG_RESET, 18'sd0, CFG_RESET, 1'b0);
		send_corner_pixels();
		set_shifts(CFG_RESET, DEC_MAX, DEC_MAX, 1'b0);
		send_corner_pixels();
		// Lightening past one saturates the channels.
		set_shifts(CFG_RESET, 18'sd0, 18'sd131071, 1'b0);
		send_corner_pixels();
		set_shifts(18'sd0, CFG_RESET, CFG_RESET, 1'b0);
		send_corner_pixels();
		// Hue above one is no hue shift; saturation increase is unsupported.
		set_shifts(18'sd65537, Q16_ONE, 18'sd32800, 1'b1);
		send_corner_pixels();

		// Random part: a new setting per phase, one long phase under back-pressure.
		phase_no = 0;
		while (pixels_queued < RANDOM_PIXELS) begin
			h = ($urandom_range(99) < 70) ? -18'sd1 : pick_shift();
			set_shifts(h, pick_shift(), pick_shift(), $urandom_range(3) == 0);
			phase_len = (phase_no == 5) ? 90 : $urandom_range(70, 15);
			repeat (phase_len)
				send_pixel(make_pixel());
			if (phase_no == 5)
				hold_req = 1'b1;
			phase_no++;
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_shifted.size() != 0) begin
			$error("%0d expected pixels never arrived", pending_shifted.size());
			err_count++;
		end
		if (err_count == 0)
			$display("[premultiplied_hsl_shift] OK");
		else
			$display("[premultiplied_hsl_shift] ERROR");
		$finish;
	end

endmodule
